// ===== sv/tzd_pkg.sv =====
`default_nettype none
package tzd_pkg;

  localparam int LAYOUT_DEPTH = 64;
  localparam int ACTION_DEPTH = 32;

  localparam int LAYOUT_AW = $clog2(LAYOUT_DEPTH);
  localparam int ACTION_AW = $clog2(ACTION_DEPTH);
  localparam int POS_W     = $clog2(LAYOUT_DEPTH + 1);
  localparam int CELL_W    = $clog2(LAYOUT_DEPTH + 1);
  // edges: 16-bit origin plus at most LAYOUT_DEPTH 16-bit steps
  localparam int EDGE_W    = 16 + $clog2(LAYOUT_DEPTH + 1);

  localparam int FUNC_W    = 2;
  localparam int SLOT_W    = 6;
  localparam int WORD_W    = 16;
  localparam int COORD_W   = 16;
  localparam int ACT_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_LAYOUT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACTION = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TOUCH  = 2'd2;

  localparam logic [7:0] TOK_ORIGIN = 8'd1;
  localparam logic [7:0] TOK_SIZE   = 8'd2;
  localparam logic [7:0] TOK_ROW    = 8'd3;
  localparam logic [7:0] TOK_COL    = 8'd4;
  localparam logic [7:0] TOK_END    = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_W    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_H    = 3'd4;

  localparam logic [CFG_DAT_W-1:0] THRESHOLD_RESET = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } ctrl_state_t;

  typedef enum logic [2:0] {
    PH_TOKEN = 3'b001,
    PH_OPX   = 3'b010,
    PH_OPY   = 3'b100
  } phase_t;

  typedef struct packed {
    logic start;
    logic step;
    logic wr_layout;
    logic wr_action;
    logic load_out;
  } tzd_cmd_t;

  typedef struct packed {
    logic press_ok;
    logic walk_end;
  } tzd_sts_t;

endpackage
`default_nettype wire

// ===== sv/tzd_sample_if.sv =====
`default_nettype none
interface tzd_sample_if;
  logic                              valid;
  logic                              ready;
  logic [tzd_pkg::FUNC_W-1:0]        func;
  logic [tzd_pkg::SLOT_W-1:0]        slot;
  logic [tzd_pkg::WORD_W-1:0]        load_word;
  logic                              touching;
  logic [tzd_pkg::COORD_W-1:0]       touch_x;
  logic [tzd_pkg::COORD_W-1:0]       touch_y;
  logic [tzd_pkg::COORD_W-1:0]       touch_z;

  modport source (output valid, func, slot, load_word, touching, touch_x, touch_y, touch_z,
                  input ready);
  modport sink (input valid, func, slot, load_word, touching, touch_x, touch_y, touch_z,
                output ready);
endinterface
`default_nettype wire

// ===== sv/tzd_result_if.sv =====
`default_nettype none
interface tzd_result_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic [tzd_pkg::ACT_W-1:0]         action;
  logic [tzd_pkg::COORD_W-1:0]       zone_x;
  logic [tzd_pkg::COORD_W-1:0]       zone_y;
  logic [tzd_pkg::COORD_W-1:0]       zone_w;
  logic [tzd_pkg::COORD_W-1:0]       zone_h;

  modport source (output valid, hit, action, zone_x, zone_y, zone_w, zone_h, input ready);
  modport sink (input valid, hit, action, zone_x, zone_y, zone_w, zone_h, output ready);
endinterface
`default_nettype wire

// ===== sv/tzd_cfg_if.sv =====
`default_nettype none
interface tzd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tzd_pkg::CFG_IDX_W-1:0]     index;
  logic [tzd_pkg::CFG_DAT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/tzd_ctrl.sv =====
`default_nettype none
module tzd_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [tzd_pkg::FUNC_W-1:0] in_func,
  input  wire logic                       in_touching,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  input  wire tzd_pkg::tzd_sts_t          sts,
  output tzd_pkg::tzd_cmd_t               cmd
);
  import tzd_pkg::*;

  ctrl_state_t state, state_next;
  logic        latched, latched_next;
  logic        out_valid_next;
  logic        accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    latched_next = latched;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_LAYOUT: cmd.wr_layout = 1'b1;
            FUNC_ACTION: cmd.wr_action = 1'b1;
            FUNC_TOUCH: begin
              if (!in_touching) begin
                latched_next = 1'b0;
              end else if (!latched && sts.press_ok) begin
                latched_next = 1'b1;
                cmd.start    = 1'b1;
                state_next   = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (sts.walk_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      latched   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      latched   <= latched_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tzd_datapath.sv =====
`default_nettype none
module tzd_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tzd_pkg::tzd_cmd_t           cmd,
  output tzd_pkg::tzd_sts_t                sts,
  tzd_cfg_if.sink                          cfg,
  input  wire logic [tzd_pkg::SLOT_W-1:0]  in_slot,
  input  wire logic [tzd_pkg::WORD_W-1:0]  in_word,
  input  wire logic [tzd_pkg::COORD_W-1:0] in_x,
  input  wire logic [tzd_pkg::COORD_W-1:0] in_y,
  input  wire logic [tzd_pkg::COORD_W-1:0] in_z,
  output logic                             out_hit,
  output logic [tzd_pkg::ACT_W-1:0]        out_action,
  output logic [tzd_pkg::COORD_W-1:0]      out_x,
  output logic [tzd_pkg::COORD_W-1:0]      out_y,
  output logic [tzd_pkg::COORD_W-1:0]      out_w,
  output logic [tzd_pkg::COORD_W-1:0]      out_h
);
  import tzd_pkg::*;

  logic [WORD_W-1:0]    layout_mem [LAYOUT_DEPTH];
  logic [ACT_W-1:0]     action_mem [ACTION_DEPTH];
  logic [WORD_W-1:0]    rdata;
  logic [ACT_W-1:0]     act_rdata;
  logic [LAYOUT_AW-1:0] rd_addr;

  logic [CFG_DAT_W-1:0] threshold, def_ox, def_oy, def_cw, def_ch;

  logic [POS_W-1:0]     tok_pos;
  logic [CELL_W-1:0]    cell_cnt;
  phase_t               phase;
  logic                 op_origin;
  logic                 across;
  logic                 found;
  logic [COORD_W-1:0]   px, py;
  logic [WORD_W-1:0]    ox, oy, cw, ch;
  logic [EDGE_W-1:0]    xa, xb, ya, yb;

  logic [7:0]           tok;
  logic                 tok_special, cell_tok, is_last, early_stop, hit, act_ok;
  logic [EDGE_W-1:0]    tok_e, sum, na_x, nb_x, na_y, nb_y, px_e, py_e, dx, dy;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      def_ox    <= '0;
      def_oy    <= '0;
      def_cw    <= '0;
      def_ch    <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_THRESHOLD: threshold <= cfg.data;
        CFG_ORIGIN_X:  def_ox    <= cfg.data;
        CFG_ORIGIN_Y:  def_oy    <= cfg.data;
        CFG_CELL_W:    def_cw    <= cfg.data;
        CFG_CELL_H:    def_ch    <= cfg.data;
        default: ;
      endcase
    end
  end

  // stores
  assign rd_addr = cmd.start ? '0 : LAYOUT_AW'(tok_pos + POS_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.wr_layout && (32'(in_slot) < LAYOUT_DEPTH)) begin
      layout_mem[LAYOUT_AW'(in_slot)] <= in_word;
    end
    rdata <= layout_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_action && (32'(in_slot) < ACTION_DEPTH)) begin
      action_mem[ACTION_AW'(in_slot)] <= in_word[ACT_W-1:0];
    end
    act_rdata <= action_mem[ACTION_AW'(cell_cnt)];
  end

  // token decode and hit test
  assign tok         = rdata[7:0];
  assign tok_special = (tok == TOK_ORIGIN) || (tok == TOK_SIZE) || (tok == TOK_ROW) ||
                       (tok == TOK_COL) || (tok == TOK_END);
  assign cell_tok    = (phase == PH_TOKEN) && !tok_special;
  assign tok_e       = EDGE_W'(tok);
  assign sum         = (across ? xb : yb) + tok_e;
  assign na_x        = across ? xb : xa;
  assign nb_x        = across ? sum : xb;
  assign na_y        = across ? ya : yb;
  assign nb_y        = across ? yb : sum;
  assign px_e        = EDGE_W'(px);
  assign py_e        = EDGE_W'(py);
  assign hit         = cell_tok && (py_e >= na_y) && (py_e < nb_y) &&
                       (px_e >= na_x) && (px_e < nb_x);
  assign is_last     = (tok_pos == POS_W'(LAYOUT_DEPTH - 1));
  // stop at the end marker, or where operands would run past the end of the store
  assign early_stop  = (phase == PH_TOKEN) &&
                       ((tok == TOK_END) ||
                        (((tok == TOK_ORIGIN) || (tok == TOK_SIZE)) &&
                         (32'(tok_pos) > LAYOUT_DEPTH - 3)));

  assign sts.press_ok = (in_z >= threshold);
  assign sts.walk_end = is_last || early_stop || hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TOKEN;
    end else if (cmd.start) begin
      phase <= PH_TOKEN;
    end else if (cmd.step) begin
      case (phase)
        PH_TOKEN: begin
          if ((tok == TOK_ORIGIN) || (tok == TOK_SIZE)) begin
            phase <= PH_OPX;
          end
        end
        PH_OPX:  phase <= PH_OPY;
        PH_OPY:  phase <= PH_TOKEN;
        default: phase <= PH_TOKEN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tok_pos   <= '0;
      cell_cnt  <= '0;
      found     <= 1'b0;
      across    <= 1'b1;
      op_origin <= 1'b0;
      px        <= in_x;
      py        <= in_y;
      ox        <= def_ox;
      oy        <= def_oy;
      cw        <= def_cw;
      ch        <= def_ch;
      xa        <= '0;
      xb        <= '0;
      ya        <= '0;
      yb        <= '0;
    end else if (cmd.step) begin
      tok_pos <= tok_pos + POS_W'(1);
      case (phase)
        PH_TOKEN: begin
          if (cell_tok) begin
            xa <= na_x;
            xb <= nb_x;
            ya <= na_y;
            yb <= nb_y;
            if (hit) begin
              found <= 1'b1;
            end else begin
              cell_cnt <= cell_cnt + CELL_W'(1);
            end
          end else if (tok == TOK_ROW) begin
            across <= 1'b1;
            ya     <= yb;
            yb     <= yb + EDGE_W'(ch);
            xb     <= EDGE_W'(ox);
          end else if (tok == TOK_COL) begin
            across <= 1'b0;
            xa     <= xb;
            xb     <= xb + EDGE_W'(cw);
            yb     <= EDGE_W'(oy);
          end else if (tok == TOK_ORIGIN) begin
            op_origin <= 1'b1;
          end else if (tok == TOK_SIZE) begin
            op_origin <= 1'b0;
          end
        end
        PH_OPX: begin
          if (op_origin) begin
            ox <= rdata;
            xb <= EDGE_W'(rdata);
          end else begin
            cw <= rdata;
          end
        end
        PH_OPY: begin
          if (op_origin) begin
            oy <= rdata;
            yb <= EDGE_W'(rdata);
          end else begin
            ch <= rdata;
          end
        end
        default: ;
      endcase
    end
  end

  // result word
  assign act_ok = (32'(cell_cnt) < ACTION_DEPTH);
  assign dx     = xb - xa;
  assign dy     = yb - ya;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_hit    <= found;
      out_action <= (found && act_ok) ? act_rdata : '0;
      out_x      <= found ? xa[COORD_W-1:0] : '0;
      out_y      <= found ? ya[COORD_W-1:0] : '0;
      out_w      <= found ? dx[COORD_W-1:0] : '0;
      out_h      <= found ? dy[COORD_W-1:0] : '0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/touch_zone_decoder.sv =====
`default_nettype none
// Touch zone decoder. Load words (func 0 layout word, func 1 action entry) are written to
// the RAMs. A touch sample is simply taken unless it is a new press at or above the
// pressure threshold; then the layout script is walked one word per cycle out of the layout
// RAM, and the press holds the sample channel through the start, the word reads, and the
// action code fetch and result register load. The walk ends at the end marker, at an origin
// or size token whose operands would overrun the store, at the first cell holding the point,
// or at the last word. One result word comes per such press, from an output register, so the
// next sample is taken while a result is still waiting; a press whose walk ends while the
// previous result word still waits holds the sample channel until that word is taken.
// Configuration writes are always ready.
module touch_zone_decoder (
  input wire logic clk,
  input wire logic rst,
  tzd_sample_if.sink   sample,
  tzd_result_if.source result,
  tzd_cfg_if.sink      cfg
);
  import tzd_pkg::*;

  tzd_cmd_t cmd;
  tzd_sts_t sts;

  tzd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (sample.valid),
    .in_ready    (sample.ready),
    .in_func     (sample.func),
    .in_touching (sample.touching),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  tzd_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (cfg),
    .in_slot    (sample.slot),
    .in_word    (sample.load_word),
    .in_x       (sample.touch_x),
    .in_y       (sample.touch_y),
    .in_z       (sample.touch_z),
    .out_hit    (result.hit),
    .out_action (result.action),
    .out_x      (result.zone_x),
    .out_y      (result.zone_y),
    .out_w      (result.zone_w),
    .out_h      (result.zone_h)
  );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
module testbench;
  import tzd_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_PER_PHASE = 125;
  localparam int HOLD_CYCLES      = 400;
  localparam int DRAIN_CYCLES     = LAYOUT_DEPTH + 16;

  typedef struct packed {
    logic               hit;
    logic [ACT_W-1:0]   action;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } zone_t;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [SLOT_W-1:0]  slot;
    logic [WORD_W-1:0]  load_word;
    logic               touching;
    logic [COORD_W-1:0] touch_x;
    logic [COORD_W-1:0] touch_y;
    logic [COORD_W-1:0] touch_z;
  } sample_t;

  class zone_scoreboard;
    logic [WORD_W-1:0] layout_mem [LAYOUT_DEPTH];
    logic [ACT_W-1:0]  action_mem [ACTION_DEPTH];
    bit                latched;
    logic [15:0]       threshold, org_x, org_y, cell_w, cell_h;
    zone_t             pending_zones [$];
    int                mismatches;

    function new();
      latched    = 1'b0;
      threshold  = THRESHOLD_RESET;
      org_x      = '0;
      org_y      = '0;
      cell_w     = '0;
      cell_h     = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        CFG_THRESHOLD: threshold = val;
        CFG_ORIGIN_X:  org_x = val;
        CFG_ORIGIN_Y:  org_y = val;
        CFG_CELL_W:    cell_w = val;
        CFG_CELL_H:    cell_h = val;
        default: ;
      endcase
    endfunction

    // walk the layout script; first cell holding the point wins
    function zone_t find_zone(logic [15:0] px, logic [15:0] py);
      zone_t       z;
      logic [31:0] ox, oy, cw, ch, xa, xb, ya, yb;
      logic [7:0]  tok;
      bit          across;
      int unsigned pos, cell_idx;
      z = '0;
      ox = org_x;
      oy = org_y;
      cw = cell_w;
      ch = cell_h;
      xa = 0;
      xb = 0;
      ya = 0;
      yb = 0;
      across = 1'b1;
      pos = 0;
      cell_idx = 0;
      while (pos < LAYOUT_DEPTH) begin
        tok = layout_mem[pos][7:0];
        pos++;
        if (tok == TOK_END) break;
        if (tok == TOK_ORIGIN || tok == TOK_SIZE) begin
          if (pos + 2 > LAYOUT_DEPTH) break;
          if (tok == TOK_ORIGIN) begin
            ox = layout_mem[pos];
            oy = layout_mem[pos + 1];
            xb = ox;
            yb = oy;
          end else begin
            cw = layout_mem[pos];
            ch = layout_mem[pos + 1];
          end
          pos += 2;
        end else if (tok == TOK_ROW) begin
          across = 1'b1;
          ya = yb;
          yb = ya + ch;
          xb = ox;
        end else if (tok == TOK_COL) begin
          across = 1'b0;
          xa = xb;
          xb = xa + cw;
          yb = oy;
        end else begin
          if (across) begin
            xa = xb;
            xb = xa + {24'd0, tok};
          end else begin
            ya = yb;
            yb = ya + {24'd0, tok};
          end
          if (py >= ya && py < yb && px >= xa && px < xb) begin
            z.hit    = 1'b1;
            z.action = (cell_idx < ACTION_DEPTH) ? action_mem[cell_idx] : '0;
            z.x      = xa[15:0];
            z.y      = ya[15:0];
            z.w      = 16'(xb - xa);
            z.h      = 16'(yb - ya);
            return z;
          end
          cell_idx++;
        end
      end
      return z;
    endfunction

    function void take_sample(sample_t s);
      case (s.func)
        FUNC_LAYOUT: layout_mem[s.slot] = s.load_word;
        FUNC_ACTION: if (s.slot < ACTION_DEPTH) action_mem[s.slot] = s.load_word[7:0];
        FUNC_TOUCH: begin
          if (!s.touching) latched = 1'b0;
          else if (!latched && s.touch_z >= threshold) begin
            latched = 1'b1;
            pending_zones.push_back(find_zone(s.touch_x, s.touch_y));
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_zone(zone_t got);
      zone_t want;
      if (pending_zones.size() == 0) begin
        report("result word with no press pending");
        return;
      end
      want = pending_zones.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("hit %0d, predicted %0d", got.hit, want.hit));
      if (got.action !== want.action)
        report($sformatf("action %0h, predicted %0h", got.action, want.action));
      if (got.x !== want.x)
        report($sformatf("zone_x %0h, predicted %0h", got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("zone_y %0h, predicted %0h", got.y, want.y));
      if (got.w !== want.w)
        report($sformatf("zone_w %0h, predicted %0h", got.w, want.w));
      if (got.h !== want.h)
        report($sformatf("zone_h %0h, predicted %0h", got.h, want.h));
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;

  tzd_sample_if sample_ch ();
  tzd_result_if result_ch ();
  tzd_cfg_if    cfg_ch ();

  touch_zone_decoder u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  zone_scoreboard sb = new();

  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;
  int          items_sent     = 0;
  int          hold_seq       = 0;
  int          hold_seen      = 0;
  int          hold_left      = 0;
  logic [15:0] near_x         = '0;
  logic [15:0] near_y         = '0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_zone({result_ch.hit, result_ch.action, result_ch.zone_x, result_ch.zone_y,
                     result_ch.zone_w, result_ch.zone_h});
  end

  // entered at a falling edge; leaves valid high for a back-to-back word
  task automatic put_sample(input sample_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.func      <= it.func;
    sample_ch.slot      <= it.slot;
    sample_ch.load_word <= it.load_word;
    sample_ch.touching  <= it.touching;
    sample_ch.touch_x   <= it.touch_x;
    sample_ch.touch_y   <= it.touch_y;
    sample_ch.touch_z   <= it.touch_z;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sb.take_sample(it);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic sample_t rand_item();
    sample_t it;
    it.func      = 2'($urandom_range(0, 3));
    it.slot      = 6'($urandom);
    it.load_word = 16'($urandom);
    it.touching  = 1'($urandom);
    it.touch_x   = 16'($urandom);
    it.touch_y   = 16'($urandom);
    it.touch_z   = 16'($urandom);
    return it;
  endfunction

  task automatic load_layout(input logic [SLOT_W-1:0] slot, input logic [WORD_W-1:0] word);
    sample_t it;
    it = rand_item();
    it.func = FUNC_LAYOUT;
    it.slot = slot;
    it.load_word = word;
    put_sample(it);
  endtask

  task automatic load_action(input logic [SLOT_W-1:0] slot, input logic [WORD_W-1:0] word);
    sample_t it;
    it = rand_item();
    it.func = FUNC_ACTION;
    it.slot = slot;
    it.load_word = word;
    put_sample(it);
  endtask

  task automatic touch(input logic t, input logic [15:0] x, input logic [15:0] y,
                       input logic [15:0] z);
    sample_t it;
    it = rand_item();
    it.func = FUNC_TOUCH;
    it.touching = t;
    it.touch_x = x;
    it.touch_y = y;
    it.touch_z = z;
    put_sample(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic start_phase(input logic [15:0] thr, input logic [15:0] ox,
                             input logic [15:0] oy, input logic [15:0] cw,
                             input logic [15:0] ch, input int idle_pct, input int stall_pct);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_CELL_W, cw);
    write_reg(CFG_CELL_H, ch);
    near_x = ox;
    near_y = oy;
  endtask

  task automatic end_phase();
    sample_ch.valid <= 1'b0;
    while (sb.pending_zones.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] cell_code();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r < 8) return 8'($urandom_range(5, 60));
    return 8'($urandom_range(5, 254));
  endfunction

  function automatic logic [15:0] small_or_any(input int hi);
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, hi));
  endfunction

  function automatic logic [15:0] press_z();
    if ($urandom_range(3) == 0) return sb.threshold;
    return 16'($urandom_range(int'(sb.threshold), 65535));
  endfunction

  function automatic logic [15:0] near_coord(input logic [15:0] base);
    if ($urandom_range(7) == 0) return 16'($urandom);
    return base + 16'($urandom_range(0, 350));
  endfunction

  task automatic load_random_script();
    logic [15:0] words [$];
    logic [15:0] ox_w, oy_w;
    int          lines;
    near_x = sb.org_x;
    near_y = sb.org_y;
    if ($urandom_range(3) != 0) begin
      ox_w = small_or_any(300);
      oy_w = small_or_any(300);
      words.push_back({8'($urandom), TOK_ORIGIN});
      words.push_back(ox_w);
      words.push_back(oy_w);
      near_x = ox_w;
      near_y = oy_w;
    end
    if ($urandom_range(3) != 0) begin
      words.push_back({8'($urandom), TOK_SIZE});
      words.push_back(small_or_any(60));
      words.push_back(small_or_any(60));
    end
    lines = $urandom_range(1, 5);
    repeat (lines) begin
      words.push_back({8'($urandom), $urandom_range(1) ? TOK_ROW : TOK_COL});
      repeat ($urandom_range(0, 8)) words.push_back({8'($urandom), cell_code()});
      if ($urandom_range(7) == 0) begin
        words.push_back({8'($urandom), TOK_ORIGIN});
        words.push_back(near_x + 16'($urandom_range(0, 200)));
        words.push_back(near_y + 16'($urandom_range(0, 200)));
      end
    end
    if ($urandom_range(5) != 0) words.push_back({8'($urandom), TOK_END});
    for (int i = 0; i < words.size() && i < LAYOUT_DEPTH; i++) load_layout(6'(i), words[i]);
    if ($urandom_range(1) == 0)
      repeat ($urandom_range(1, 8)) load_action(6'($urandom_range(0, 63)), 16'($urandom));
  endtask

  task automatic press_burst();
    touch(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
    touch(1'b1, near_coord(near_x), near_coord(near_y), press_z());
    repeat ($urandom_range(0, 2)) touch(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    if ($urandom_range(3) == 0) begin
      touch(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
      if (sb.threshold != 0)
        touch(1'b1, near_coord(near_x), near_coord(near_y),
              16'($urandom_range(0, int'(sb.threshold) - 1)));
    end
  endtask

  task automatic run_random(input int count);
    int stop_at;
    int r;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 15) load_random_script();
      else if (r < 25) put_sample(rand_item());
      else press_burst();
    end
  endtask

  initial begin
    sample_t item;
    sample_ch.valid     = 1'b0;
    sample_ch.func      = FUNC_LAYOUT;
    sample_ch.slot      = '0;
    sample_ch.load_word = '0;
    sample_ch.touching  = 1'b0;
    sample_ch.touch_x   = '0;
    sample_ch.touch_y   = '0;
    sample_ch.touch_z   = '0;
    result_ch.ready     = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_THRESHOLD;
    cfg_ch.data         = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    start_phase(THRESHOLD_RESET, 16'd0, 16'd0, 16'd0, 16'd0, 0, 0);
    for (int i = 0; i < LAYOUT_DEPTH; i++) load_layout(6'(i), 16'($urandom));
    for (int i = 0; i < ACTION_DEPTH; i++) load_action(6'(i), 16'($urandom));
    touch(1'b0, 16'd0, 16'd0, 16'd0);
    touch(1'b1, 16'd0, 16'd0, THRESHOLD_RESET - 16'd1);
    touch(1'b1, 16'd0, 16'd0, THRESHOLD_RESET);
    touch(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    touch(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    touch(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    item = rand_item();
    item.func = FUNC_UNUSED;
    put_sample(item);
    load_action(6'd40, 16'hFFFF);

    // one long row that fills the whole layout store
    load_layout(6'd0, {8'($urandom), TOK_SIZE});
    load_layout(6'd1, 16'd8);
    load_layout(6'd2, 16'd20);
    load_layout(6'd3, {8'($urandom), TOK_ROW});
    for (int i = 4; i < LAYOUT_DEPTH; i++) load_layout(6'(i), {8'($urandom), 8'd5});
    touch(1'b0, 16'd0, 16'd0, 16'd0);
    touch(1'b1, 16'd297, 16'd19, 16'hFFFF);
    touch(1'b0, 16'd0, 16'd0, 16'd0);
    touch(1'b1, 16'd300, 16'd5, THRESHOLD_RESET);
    touch(1'b0, 16'd0, 16'd0, 16'd0);
    touch(1'b1, 16'd12, 16'd3, THRESHOLD_RESET);
    // operands would fall past the last word
    load_layout(6'd62, {8'($urandom), TOK_ORIGIN});
    touch(1'b0, 16'd0, 16'd0, 16'd0);
    touch(1'b1, 16'd292, 16'd5, THRESHOLD_RESET);
    load_layout(6'd62, {8'($urandom), TOK_SIZE});
    touch(1'b0, 16'd0, 16'd0, 16'd0);
    touch(1'b1, 16'd292, 16'd5, THRESHOLD_RESET);

    // edges past 16 bits
    load_layout(6'd0, {8'($urandom), TOK_ORIGIN});
    load_layout(6'd1, 16'd65530);
    load_layout(6'd2, 16'd65530);
    load_layout(6'd3, {8'($urandom), TOK_SIZE});
    load_layout(6'd4, 16'd0);
    load_layout(6'd5, 16'd100);
    load_layout(6'd6, {8'($urandom), TOK_ROW});
    load_layout(6'd7, {8'($urandom), 8'd200});
    load_layout(6'd8, {8'($urandom), TOK_END});
    touch(1'b0, 16'd0, 16'd0, 16'd0);
    touch(1'b1, 16'd65533, 16'd65535, THRESHOLD_RESET);

    // origin moved above the row: far edge below near edge
    load_layout(6'd0, {8'($urandom), TOK_ORIGIN});
    load_layout(6'd1, 16'd0);
    load_layout(6'd2, 16'd100);
    load_layout(6'd3, {8'($urandom), TOK_SIZE});
    load_layout(6'd4, 16'd10);
    load_layout(6'd5, 16'd50);
    load_layout(6'd6, {8'($urandom), TOK_ROW});
    load_layout(6'd7, {8'($urandom), TOK_ORIGIN});
    load_layout(6'd8, 16'd0);
    load_layout(6'd9, 16'd10);
    load_layout(6'd10, {8'($urandom), 8'd30});
    load_layout(6'd11, {8'($urandom), TOK_COL});
    load_layout(6'd12, {8'($urandom), 8'd20});
    load_layout(6'd13, {8'($urandom), TOK_END});
    touch(1'b0, 16'd0, 16'd0, 16'd0);
    touch(1'b1, 16'd5, 16'd105, THRESHOLD_RESET);
    touch(1'b0, 16'd0, 16'd0, 16'd0);
    touch(1'b1, 16'd35, 16'd15, THRESHOLD_RESET);
    run_random(RANDOM_PER_PHASE);
    end_phase();

    start_phase(16'd0, 16'd0, 16'd0, 16'd10, 16'd10, 62, 0);
    run_random(RANDOM_PER_PHASE);
    end_phase();

    start_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 62);
    run_random(RANDOM_PER_PHASE);
    end_phase();

    start_phase(16'd500, 16'd20, 16'd40, 16'd16, 16'd12, 25, 25);
    run_random(RANDOM_PER_PHASE);
    end_phase();

    // result side held off while presses keep coming
    start_phase(THRESHOLD_RESET, 16'd0, 16'd0, 16'd25, 16'd15, 0, 0);
    hold_seq <= hold_seq + 1;
    repeat (20) press_burst();
    run_random(RANDOM_PER_PHASE);
    end_phase();

    start_phase(16'($urandom), 16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)), 62, 0);
    run_random(RANDOM_PER_PHASE);
    end_phase();

    start_phase(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 0, 62);
    run_random(RANDOM_PER_PHASE);
    end_phase();

    start_phase(16'($urandom_range(0, 2000)), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 25, 25);
    run_random(RANDOM_PER_PHASE);
    end_phase();

    if (sb.mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
`default_nettype wire
